// ----- design/hsvrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter
// Fixed-point formats, sector codes and the input clamp used by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  // Q1.16 fixed point: ONE means 1.0
  localparam int FRAC_BITS = 16;
  localparam int UNIT_W    = FRAC_BITS + 1;
  localparam int HUE_W     = 16;
  localparam int IN_W      = FRAC_BITS + 2;
  localparam int H6_W      = HUE_W + 3;

  typedef logic [UNIT_W-1:0] unit_t;
  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [IN_W-1:0]   raw_t;

  localparam unit_t ONE = unit_t'(1) << FRAC_BITS;

  // Hue sector, one sixth of a turn each
  typedef enum logic [2:0] {
    SECTOR_RED_YEL  = 3'd0,
    SECTOR_YEL_GRN  = 3'd1,
    SECTOR_GRN_CYN  = 3'd2,
    SECTOR_CYN_BLU  = 3'd3,
    SECTOR_BLU_MAG  = 3'd4,
    SECTOR_MAG_RED  = 3'd5
  } sector_t;

  // Clamp a signed Q1.16 value to 0..ONE
  function automatic unit_t clamp_unit(raw_t raw);
    unit_t mag;
    mag = raw[UNIT_W-1:0];
    if (raw[IN_W-1]) begin
      return '0;
    end else if (raw[IN_W-2] || (mag > ONE)) begin
      return ONE;
    end else begin
      return mag;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/hsvrgb_in_if.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_in_if: HSV pixel channel
// Valid/ready handshake carrying hue, saturation, value and alpha per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_in_if;
  logic                  valid;
  logic                  ready;
  hsvrgb_pkg::hue_t      hue_turn;
  logic signed [17:0]    saturation_in;
  logic signed [17:0]    value_in;
  logic [16:0]           alpha_in;

  modport source (output valid, hue_turn, saturation_in, value_in, alpha_in,
                  input ready);
  modport sink   (input valid, hue_turn, saturation_in, value_in, alpha_in,
                  output ready);
endinterface

`default_nettype wire

// ----- design/hsvrgb_out_if.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_out_if: RGB pixel channel
// Valid/ready handshake carrying red, green, blue and alpha per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvrgb_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] red_out;
  logic [16:0] green_out;
  logic [16:0] blue_out;
  logic [16:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                  output ready);
endinterface

`default_nettype wire

// ----- design/hsv_to_rgb_converter_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit: pipelined HSV to RGB color converter
// Clamps S and V, splits hue into sector and fraction, forms m = V(1-S) and
// n = V(1-S*f) and routes V, m, n to red, green and blue by sector.
// ----------------------------------------------------------------------------
//
//   channel  | port    | beat contents
//   ---------+---------+---------------------------------------------------
//   pixel in | in_bus  | hue_turn, saturation_in, value_in, alpha_in
//   pixel out| out_bus | red_out, green_out, blue_out, alpha_out
//
// Throughput is one beat per cycle while the sink is ready. A beat passes four
// register stages (clamp/sector, S*f, two V products, routing) in that order
// and waits in the output register until the sink takes it. Each stage holds
// a valid bit that travels with its data. A stage advances when it is empty or
// the stage after it advances, so bubbles are squeezed out and a stalled
// output holds every stage intact. Reset (rst_n low, synchronous) clears the
// valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit (
  input  wire logic    clk,
  input  wire logic    rst_n,
  hsvrgb_in_if.sink    in_bus,
  hsvrgb_out_if.source out_bus
);

  // Stage enables: each stage loads when empty or when downstream moves
  logic en1, en2, en3, en_out;

  // Stage 1: clamped inputs, sector and mirrored fraction
  logic                vld1_r;
  hsvrgb_pkg::unit_t   s1_r, v1_r, f1_r, a1_r;
  hsvrgb_pkg::sector_t sec1_r;
  logic                grey1_r;

  // Stage 2: S*f product, 1-S
  logic                vld2_r;
  hsvrgb_pkg::unit_t   sf2_r, oms2_r, v2_r, a2_r;
  hsvrgb_pkg::sector_t sec2_r;
  logic                grey2_r;

  // Stage 3: m and n
  logic                vld3_r;
  hsvrgb_pkg::unit_t   m3_r, n3_r, v3_r, a3_r;
  hsvrgb_pkg::sector_t sec3_r;
  logic                grey3_r;

  // Output register
  logic                out_vld_r;
  hsvrgb_pkg::unit_t   red_r, green_r, blue_r, alpha_r;
  hsvrgb_pkg::unit_t   red_nxt, green_nxt, blue_nxt;

  // Stage 1 combinational front end
  hsvrgb_pkg::unit_t           s_clamp, v_clamp, f_raw, f_mirror;
  logic [hsvrgb_pkg::H6_W-1:0] h6;

  assign en_out = !out_vld_r || out_bus.ready;
  assign en3    = !vld3_r || en_out;
  assign en2    = !vld2_r || en3;
  assign en1    = !vld1_r || en2;

  assign in_bus.ready = en1;

  assign s_clamp = hsvrgb_pkg::clamp_unit(in_bus.saturation_in);
  assign v_clamp = hsvrgb_pkg::clamp_unit(in_bus.value_in);

  // Six sectors per turn: sector in the top bits, fraction below
  assign h6       = {3'b000, in_bus.hue_turn} * hsvrgb_pkg::H6_W'(6);
  assign f_raw    = {1'b0, h6[hsvrgb_pkg::HUE_W-1:0]};
  // Mirror the fraction in even sectors
  assign f_mirror = h6[hsvrgb_pkg::HUE_W] ? f_raw : (hsvrgb_pkg::ONE - f_raw);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (en1)    vld1_r    <= in_bus.valid;
      if (en2)    vld2_r    <= vld1_r;
      if (en3)    vld3_r    <= vld2_r;
      if (en_out) out_vld_r <= vld3_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r    <= s_clamp;
      v1_r    <= v_clamp;
      f1_r    <= f_mirror;
      a1_r    <= in_bus.alpha_in;
      sec1_r  <= hsvrgb_pkg::sector_t'(h6[hsvrgb_pkg::H6_W-1:hsvrgb_pkg::HUE_W]);
      grey1_r <= (s_clamp == '0);
    end
  end

  // Stage 2: S*f in its own multiplier, carry the rest
  hsvrgb_mul u_mul_sf (
    .clk (clk),
    .en  (en2),
    .a   (s1_r),
    .b   (f1_r),
    .p_r (sf2_r)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      oms2_r  <= hsvrgb_pkg::ONE - s1_r;
      v2_r    <= v1_r;
      a2_r    <= a1_r;
      sec2_r  <= sec1_r;
      grey2_r <= grey1_r;
    end
  end

  // Stage 3: m = V(1-S), n = V(1-S*f)
  hsvrgb_mul u_mul_m (
    .clk (clk),
    .en  (en3),
    .a   (v2_r),
    .b   (oms2_r),
    .p_r (m3_r)
  );

  hsvrgb_mul u_mul_n (
    .clk (clk),
    .en  (en3),
    .a   (v2_r),
    .b   (hsvrgb_pkg::ONE - sf2_r),
    .p_r (n3_r)
  );

  always_ff @(posedge clk) begin
    if (en3) begin
      v3_r    <= v2_r;
      a3_r    <= a2_r;
      sec3_r  <= sec2_r;
      grey3_r <= grey2_r;
    end
  end

  // Route V, m and n by sector; zero saturation gives grey
  always_comb begin
    red_nxt   = v3_r;
    green_nxt = v3_r;
    blue_nxt  = v3_r;
    if (!grey3_r) begin
      unique case (sec3_r)
        hsvrgb_pkg::SECTOR_RED_YEL: begin
          red_nxt = v3_r; green_nxt = n3_r; blue_nxt = m3_r;
        end
        hsvrgb_pkg::SECTOR_YEL_GRN: begin
          red_nxt = n3_r; green_nxt = v3_r; blue_nxt = m3_r;
        end
        hsvrgb_pkg::SECTOR_GRN_CYN: begin
          red_nxt = m3_r; green_nxt = v3_r; blue_nxt = n3_r;
        end
        hsvrgb_pkg::SECTOR_CYN_BLU: begin
          red_nxt = m3_r; green_nxt = n3_r; blue_nxt = v3_r;
        end
        hsvrgb_pkg::SECTOR_BLU_MAG: begin
          red_nxt = n3_r; green_nxt = m3_r; blue_nxt = v3_r;
        end
        default: begin
          red_nxt = v3_r; green_nxt = m3_r; blue_nxt = n3_r;
        end
      endcase
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (en_out) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= a3_r;
    end
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.red_out   = red_r;
  assign out_bus.green_out = green_r;
  assign out_bus.blue_out  = blue_r;
  assign out_bus.alpha_out = alpha_r;

endmodule

`default_nettype wire

// ----- design/hsvrgb_mul.sv -----
// ----------------------------------------------------------------------------
// hsvrgb_mul: registered Q1.16 multiplier
// Multiplies two unit values and keeps the truncated Q1.16 product.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_mul (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire hsvrgb_pkg::unit_t a,
  input  wire hsvrgb_pkg::unit_t b,
  output hsvrgb_pkg::unit_t      p_r
);

  logic [2*hsvrgb_pkg::UNIT_W-1:0] prod;

  assign prod = {{hsvrgb_pkg::UNIT_W{1'b0}}, a} * {{hsvrgb_pkg::UNIT_W{1'b0}}, b};

  // Both operands stay within 0..ONE, so the product fits a unit value
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= prod[hsvrgb_pkg::FRAC_BITS +: hsvrgb_pkg::UNIT_W];
    end
  end

endmodule

`default_nettype wire
